/* sv/shid_pkg.sv */
// Shared types and constants for the SNR histogram interference detector.
package shid_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HIST_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTF_THRESHOLD = 3'd4;

	localparam int BG_HALVE_AT = 500;

	typedef struct packed {
		logic signed [15:0] snr;
		logic missing;
		logic last;
	} gate_t;

	typedef struct packed {
		logic intf_found;
		logic signed [15:0] mode_snr;
		logic signed [15:0] intf_snr;
		logic signed [15:0] background_snr;
		logic [5:0] mode_bin;
	} result_t;

endpackage

/* sv/shid_if.sv */
// Valid/ready channel carrying one payload.
interface shid_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/shid_divider.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module shid_divider #(
	parameter int NW = 40,
	parameter int DW = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic busy,
	output logic signed [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] mag_q;
	logic [NW-1:0] q_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] den_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [DW+1:0] trial;

	assign trial = {rem_q, mag_q[NW-1]} - {2'b00, den_q};
	assign busy = cnt_q != '0;
	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			neg_q <= num[NW-1];
			den_q <= den;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy) begin
			mag_q <= {mag_q[NW-2:0], 1'b0};
			if (!trial[DW+1]) begin
				rem_q <= trial[DW:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-1:0], mag_q[NW-1]};
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

/* sv/snr_histogram_interference_detector_top.sv */
// Top level: gate store, histogram, tail search, mean and background average.
//
//  channel | dir | payload                                   | accepted when
//  gate_in | in  | snr, missing, last                        | valid && ready
//  res_out | out | intf_found, mode_snr, intf_snr, bg, bin   | valid && ready
//  cfg     | in  | cfg_we, cfg_idx, cfg_data                 | cfg_we
//
// Gates load one per cycle while gate_in.ready is high. A last gate starts a
// segment pass: each stored non-missing gate is read, its bin found by a serial
// divide of its offset from hist_min by the bin width, and that bin incremented.
// Then mode scan, tail searches, a bin clear, sum sweep and up to two divides.
// After reset the bin memory is cleared before gates are taken.
// A result waits in the output register; the next segment loads meanwhile.
module snr_histogram_interference_detector_top #(
	parameter int MAX_GATES = 1024,
	parameter int MAX_BINS = 64
) (
	input logic clk,
	input logic arst_n,
	shid_if.sink gate_in,
	shid_if.source res_out,
	input logic cfg_we,
	input logic [shid_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [shid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import shid_pkg::*;

	localparam int GA_W = $clog2(MAX_GATES);
	localparam int GC_W = $clog2(MAX_GATES + 1);
	localparam int BA_W = $clog2(MAX_BINS);
	localparam int BC_W = $clog2(MAX_BINS + 1);
	localparam int SPAN_W = BA_W + 15;
	localparam int NW = 40;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_LOAD = 4'd1;
	localparam logic [3:0] ST_HIST = 4'd2;
	localparam logic [3:0] ST_MODE = 4'd3;
	localparam logic [3:0] ST_LOW = 4'd4;
	localparam logic [3:0] ST_HIGH = 4'd5;
	localparam logic [3:0] ST_LIM = 4'd6;
	localparam logic [3:0] ST_SUM = 4'd7;
	localparam logic [3:0] ST_DIV = 4'd8;
	localparam logic [3:0] ST_BG = 4'd9;
	localparam logic [3:0] ST_BGDIV = 4'd10;
	localparam logic [3:0] ST_OUT = 4'd11;
	localparam logic [3:0] ST_BGWAIT = 4'd12;

	// configuration
	logic signed [15:0] hist_min_q;
	logic [12:0] bin_width_q;
	logic [6:0] bin_count_q;
	logic [15:0] tail_level_q;
	logic signed [15:0] intf_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_min_q <= -16'sd160;
			bin_width_q <= 13'd16;
			bin_count_q <= 7'd64;
			tail_level_q <= 16'd1311;
			intf_threshold_q <= 16'sd48;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HIST_MIN: hist_min_q <= cfg_data;
				REG_BIN_WIDTH: bin_width_q <= cfg_data[12:0];
				REG_BIN_COUNT: bin_count_q <= cfg_data[6:0];
				REG_TAIL_LEVEL: tail_level_q <= cfg_data;
				REG_INTF_THRESHOLD: intf_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [12:0] bw;
	logic [BC_W-1:0] nb;
	assign bw = (bin_width_q == '0) ? 13'd1 : bin_width_q;
	always_comb begin
		if (bin_count_q == '0) nb = BC_W'(1);
		else if (32'(bin_count_q) > MAX_BINS) nb = BC_W'(MAX_BINS);
		else nb = BC_W'(bin_count_q);
	end

	// memories
	logic [16:0] gmem [MAX_GATES];
	logic [16:0] grd;
	logic gwe;
	logic [GA_W-1:0] gwa, gra;
	logic [16:0] gwd;
	always_ff @(posedge clk) begin
		if (gwe) gmem[gwa] <= gwd;
		grd <= gmem[gra];
	end

	logic [GC_W-1:0] bmem [MAX_BINS];
	logic [GC_W-1:0] brd;
	logic bwe;
	logic [BA_W-1:0] bwa, bra;
	logic [GC_W-1:0] bwd;
	always_ff @(posedge clk) begin
		if (bwe) bmem[bwa] <= bwd;
		brd <= bmem[bra];
	end

	logic [3:0] st_q;
	logic [GC_W-1:0] gcnt_q;
	logic [GC_W-1:0] ptr_q;
	logic [BC_W:0] bptr_q;
	logic rd_v_s1;
	// histogram pipeline
	logic [BA_W-1:0] hidx_s2;
	logic [GC_W-1:0] total_q;
	logic [GC_W-1:0] best_q;
	logic [BA_W-1:0] mi_q;
	logic [BA_W-1:0] lo_q, hi_q;
	logic signed [NW-1:0] sum_q;
	logic [GC_W-1:0] cnt_q;
	logic signed [NW-1:0] lo2_q, hi2_q;
	logic signed [NW-1:0] mode_q;
	logic signed [25:0] bgsum_q;
	logic [8:0] bgnum_q;
	logic signed [15:0] bgavg_q;
	logic above_q, below_q;
	logic rd_b_s1;
	logic [BA_W-1:0] rb_a_s1;

	// bin index: serial divide of the offset from hist_min by the bin width
	logic div_start, div_busy;
	logic signed [NW-1:0] div_num, div_quo;
	logic [15:0] div_den;
	shid_divider #(.NW(NW), .DW(16)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo)
	);

	// histogram sub-phase: 0 read gate, 1 data, 2 divide running, 3 bin read, 4 write, 5 next gate
	logic [2:0] hph_q;
	logic signed [17:0] diff;
	assign diff = 18'(signed'(grd[15:0])) - 18'(hist_min_q);

	logic [GC_W-1:0] bfwd;
	logic bin_ok;
	logic signed [NW-1:0] idx_w;
	assign idx_w = div_quo;
	assign bin_ok = !idx_w[NW-1] && (idx_w < NW'(nb));

	logic [GC_W+16:0] tl_prod;
	logic [GC_W+16:0] bin_prod;
	assign tl_prod = (GC_W+17)'(tail_level_q) * (GC_W+17)'(total_q);
	assign bin_prod = {1'b0, brd, 16'd0};
	logic pass_tail;
	assign pass_tail = bin_prod >= tl_prod;

	// tail limit offsets from 2*hist_min: (2*bin + 1) * bin width
	logic [SPAN_W-1:0] lo_span, hi_span;
	assign lo_span = SPAN_W'({(BA_W+1)'(lo_q), 1'b1}) * SPAN_W'(bw);
	assign hi_span = SPAN_W'({(BA_W+1)'(hi_q), 1'b1}) * SPAN_W'(bw);

	logic signed [NW-1:0] v2;
	assign v2 = NW'(signed'(grd[15:0])) <<< 1;
	logic signed [GC_W+16:0] tc_m;
	assign tc_m = (GC_W+17)'(intf_threshold_q) * (GC_W+17)'(signed'({1'b0, cnt_q}));
	logic signed [NW-1:0] tc;
	assign tc = NW'(tc_m);

	logic signed [25:0] bgsum_new;
	assign bgsum_new = bgsum_q + 26'(mode_q);

	logic res_v_q;
	result_t res_q;
	assign res_out.valid = res_v_q;
	assign res_out.data = res_q;
	assign gate_in.ready = (st_q == ST_LOAD);

	always_comb begin
		gwe = 1'b0;
		gwa = gcnt_q[GA_W-1:0];
		gwd = {gate_in.data.missing, gate_in.data.snr};
		if (gate_in.valid && gate_in.ready && (32'(gcnt_q) < MAX_GATES)) gwe = 1'b1;
		gra = ptr_q[GA_W-1:0];
		bwe = 1'b0;
		bwa = bptr_q[BA_W-1:0];
		bwd = '0;
		bra = bptr_q[BA_W-1:0];
		div_start = 1'b0;
		div_num = NW'(diff);
		div_den = 16'(bw);
		bfwd = brd + 1'b1;
		case (st_q)
			ST_CLEAR: begin
				bwe = 1'b1;
			end
			ST_HIST: begin
				bra = idx_w[BA_W-1:0];
				if (hph_q == 3'd1 && !grd[16]) div_start = 1'b1;
				if (hph_q == 3'd4) begin
					bwe = 1'b1;
					bwa = hidx_s2;
					bwd = bfwd;
				end
			end
			ST_MODE, ST_LOW, ST_HIGH: begin
				bra = bptr_q[BA_W-1:0];
				// clear pass happens after search, at ST_LIM via bptr
			end
			ST_LIM: begin
				bwe = 1'b1;
			end
			ST_DIV: begin
				div_num = sum_q;
				div_den = 16'(cnt_q);
				div_start = (hph_q == 3'd0) && (cnt_q != '0);
			end
			ST_BG: begin
				div_num = NW'(bgsum_new);
				div_den = 16'(bgnum_q + 9'd1);
				div_start = below_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			gcnt_q <= '0;
			bptr_q <= '0;
			ptr_q <= '0;
			hph_q <= '0;
			res_v_q <= 1'b0;
			bgsum_q <= '0;
			bgnum_q <= '0;
			bgavg_q <= '0;
		end else begin
			if (res_out.valid && res_out.ready) res_v_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					bptr_q <= bptr_q + 1'b1;
					if (32'(bptr_q) == MAX_BINS - 1) st_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (gate_in.valid && gate_in.ready) begin
						if (32'(gcnt_q) < MAX_GATES) gcnt_q <= gcnt_q + 1'b1;
						if (gate_in.data.last) begin
							st_q <= ST_HIST;
							ptr_q <= '0;
							hph_q <= '0;
							total_q <= '0;
						end
					end
				end
				ST_HIST: begin
					case (hph_q)
						3'd0: hph_q <= 3'd1;
						3'd1: hph_q <= grd[16] ? 3'd5 : 3'd2;
						3'd2: if (!div_busy && !div_start) hph_q <= 3'd3;
						3'd3: begin
							if (bin_ok) begin
								hidx_s2 <= idx_w[BA_W-1:0];
								hph_q <= 3'd4;
							end else begin
								hph_q <= 3'd5;
							end
						end
						3'd4: begin
							total_q <= total_q + 1'b1;
							hph_q <= 3'd5;
						end
						default: begin
							hph_q <= '0;
							ptr_q <= ptr_q + 1'b1;
							if (ptr_q + 1'b1 >= gcnt_q) begin
								st_q <= ST_MODE;
								bptr_q <= '0;
								best_q <= '0;
								mi_q <= '0;
								rd_b_s1 <= 1'b0;
							end
						end
					endcase
				end
				ST_MODE: begin
					// bptr issues, rd_b_s1 marks data returning for rb_a_s1
					rd_b_s1 <= bptr_q < {1'b0, nb};
					rb_a_s1 <= bptr_q[BA_W-1:0];
					if (bptr_q < {1'b0, nb}) bptr_q <= bptr_q + 1'b1;
					if (rd_b_s1 && brd > best_q) begin
						best_q <= brd;
						mi_q <= rb_a_s1;
					end
					if (rd_b_s1 && !(bptr_q < {1'b0, nb})) begin
						st_q <= ST_LOW;
						hph_q <= '0;
					end
				end
				ST_LOW: begin
					// hph 0: set up, 1: wait read, 2: test
					case (hph_q)
						3'd0: begin
							lo_q <= mi_q;
							hi_q <= mi_q;
							if (mi_q == '0) begin
								hph_q <= '0;
								st_q <= ST_HIGH;
								bptr_q <= (BC_W+1)'(mi_q) + 1'b1;
							end else begin
								bptr_q <= (BC_W+1)'(mi_q) - 1'b1;
								hph_q <= 3'd1;
							end
						end
						3'd1: hph_q <= 3'd2;
						default: begin
							if (pass_tail) begin
								lo_q <= bptr_q[BA_W-1:0];
								if (bptr_q == '0) begin
									st_q <= ST_HIGH;
									hph_q <= '0;
									bptr_q <= (BC_W+1)'(mi_q) + 1'b1;
								end else begin
									bptr_q <= bptr_q - 1'b1;
									hph_q <= 3'd1;
								end
							end else begin
								st_q <= ST_HIGH;
								hph_q <= '0;
								bptr_q <= (BC_W+1)'(mi_q) + 1'b1;
							end
						end
					endcase
				end
				ST_HIGH: begin
					case (hph_q)
						3'd0: begin
							if (bptr_q >= {1'b0, nb}) begin
								st_q <= ST_LIM;
								bptr_q <= '0;
							end else begin
								hph_q <= 3'd1;
							end
						end
						3'd1: hph_q <= 3'd2;
						default: begin
							hph_q <= '0;
							if (pass_tail) begin
								hi_q <= bptr_q[BA_W-1:0];
								bptr_q <= bptr_q + 1'b1;
							end else begin
								st_q <= ST_LIM;
								bptr_q <= '0;
							end
						end
					endcase
				end
				ST_LIM: begin
					// also clears the bin memory for the next segment
					bptr_q <= bptr_q + 1'b1;
					if (bptr_q == '0) begin
						lo2_q <= (NW'(hist_min_q) <<< 1) + NW'(lo_span);
						hi2_q <= (NW'(hist_min_q) <<< 1) + NW'(hi_span);
					end
					if (32'(bptr_q) == MAX_BINS - 1) begin
						st_q <= ST_SUM;
						ptr_q <= '0;
						rd_v_s1 <= 1'b0;
						sum_q <= '0;
						cnt_q <= '0;
					end
				end
				ST_SUM: begin
					rd_v_s1 <= ptr_q < gcnt_q;
					if (ptr_q < gcnt_q) ptr_q <= ptr_q + 1'b1;
					if (rd_v_s1 && !grd[16] && v2 >= lo2_q && v2 <= hi2_q) begin
						sum_q <= sum_q + NW'(signed'(grd[15:0]));
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_v_s1 && !(ptr_q < gcnt_q)) begin
						st_q <= ST_DIV;
						hph_q <= '0;
					end
				end
				ST_DIV: begin
					case (hph_q)
						3'd0: begin
							hph_q <= 3'd1;
							if (cnt_q != '0) begin
								above_q <= sum_q > tc;
								below_q <= sum_q < tc;
							end else begin
								above_q <= intf_threshold_q < 0;
								below_q <= intf_threshold_q > 0;
							end
						end
						default: begin
							if (!div_busy) begin
								mode_q <= (cnt_q != '0) ? div_quo : '0;
								st_q <= ST_BG;
							end
						end
					endcase
				end
				ST_BG: begin
					if (below_q) begin
						bgsum_q <= bgsum_new;
						bgnum_q <= bgnum_q + 1'b1;
						st_q <= ST_BGWAIT;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_BGWAIT: st_q <= ST_BGDIV;
				ST_BGDIV: begin
					if (!div_busy) begin
						bgavg_q <= div_quo[15:0];
						if (32'(bgnum_q) >= BG_HALVE_AT) begin
							bgsum_q <= $signed(bgsum_q + 26'(bgsum_q[25] & bgsum_q[0])) >>> 1;
							bgnum_q <= bgnum_q >> 1;
						end
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_v_q) begin
						res_v_q <= 1'b1;
						res_q.intf_found <= above_q;
						res_q.mode_snr <= mode_q[15:0];
						res_q.intf_snr <= above_q ? mode_q[15:0] : 16'sd0;
						res_q.background_snr <= bgavg_q;
						res_q.mode_bin <= 6'(mi_q);
						gcnt_q <= '0;
						st_q <= ST_LOAD;
					end
				end
				default: st_q <= ST_CLEAR;
			endcase
		end
	end
endmodule

/* sv/shid_checker.sv */
// Port-level checks on the detector, bound to the top level.
module shid_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_found,
	input logic [15:0] out_mode,
	input logic [15:0] out_intf
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_intf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_intf == 16'd0) else $error("intf_snr nonzero");
	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_found |-> out_intf == out_mode) else $error("intf_snr mismatch");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready) else $error("gate taken mid segment");
endmodule

bind snr_histogram_interference_detector_top shid_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(gate_in.valid), .in_ready(gate_in.ready), .in_last(gate_in.data.last),
	.out_valid(res_out.valid), .out_ready(res_out.ready),
	.out_found(res_out.data.intf_found), .out_mode(res_out.data.mode_snr),
	.out_intf(res_out.data.intf_snr)
);

/* verif/snr_histogram_interference_detector_top_test.sv */
// Self-checking testbench for the SNR histogram interference detector top level.
`timescale 1ns / 1ps

module snr_histogram_interference_detector_top_test;
	import shid_pkg::*;

	localparam int GATE_DEPTH = 1024;
	localparam int BIN_DEPTH = 64;
	localparam int PASS_WAIT = 2600;
	localparam longint CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	shid_if #(.payload_t(gate_t)) gate_ch ();
	shid_if #(.payload_t(result_t)) res_ch ();

	snr_histogram_interference_detector_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.gate_in(gate_ch),
		.res_out(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// register mirror
	int hmin_m;
	int bwidth_m;
	int bcount_m;
	longint tail_m;
	int thresh_m;

	// detector state mirror
	logic signed [15:0] seg_snr [GATE_DEPTH];
	logic seg_miss [GATE_DEPTH];
	int seg_len;
	int unsigned hist [BIN_DEPTH];
	longint bg_sum;
	int bg_num;
	int bg_avg;

	gate_t gate_q [$];
	result_t segment_results [$];
	int err_count;
	longint cycles;
	int src_gap;
	int snk_gap;
	bit src_burst;
	bit snk_burst;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
		err_count++;
	endtask

	function automatic bit tail_bin(int unsigned cnt, int unsigned total);
		return longint'(cnt) * 65536 >= tail_m * longint'(total);
	endfunction

	// Store one gate; on the last gate work out the segment result.
	function automatic void track_gate(gate_t g);
		int bw, nb, idx, mi, lo, hi;
		int unsigned total, best, cnt;
		longint lo2, hi2, sum, mode_v, tc, v2;
		bit above, below;
		result_t r;
		if (seg_len < GATE_DEPTH) begin
			seg_snr[seg_len] = g.snr;
			seg_miss[seg_len] = g.missing;
			seg_len++;
		end
		if (!g.last)
			return;
		bw = (bwidth_m == 0) ? 1 : bwidth_m;
		nb = (bcount_m == 0) ? 1 : ((bcount_m > BIN_DEPTH) ? BIN_DEPTH : bcount_m);
		total = 0;
		best = 0;
		cnt = 0;
		sum = 0;
		mode_v = 0;
		foreach (hist[i])
			hist[i] = 0;
		for (int i = 0; i < seg_len; i++) begin
			if (!seg_miss[i]) begin
				idx = (int'(seg_snr[i]) - hmin_m) / bw;
				if (idx >= 0 && idx < nb) begin
					hist[idx]++;
					total++;
				end
			end
		end
		mi = 0;
		for (int i = 0; i < nb; i++) begin
			if (hist[i] > best) begin
				best = hist[i];
				mi = i;
			end
		end
		lo = mi;
		for (int i = mi - 1; i >= 0; i--) begin
			if (!tail_bin(hist[i], total))
				break;
			lo = i;
		end
		hi = mi;
		for (int i = mi + 1; i < nb; i++) begin
			if (!tail_bin(hist[i], total))
				break;
			hi = i;
		end
		lo2 = 2 * longint'(hmin_m) + (2 * longint'(lo) + 1) * bw;
		hi2 = 2 * longint'(hmin_m) + (2 * longint'(hi) + 1) * bw;
		for (int i = 0; i < seg_len; i++) begin
			if (!seg_miss[i]) begin
				v2 = 2 * longint'(seg_snr[i]);
				if (v2 >= lo2 && v2 <= hi2) begin
					sum += longint'(seg_snr[i]);
					cnt++;
				end
			end
		end
		if (cnt != 0)
			mode_v = sum / longint'(cnt);
		tc = longint'(thresh_m) * longint'(cnt);
		above = (cnt != 0) ? (sum > tc) : (thresh_m < 0);
		below = (cnt != 0) ? (sum < tc) : (thresh_m > 0);
		if (below) begin
			bg_sum += mode_v;
			bg_num++;
			bg_avg = int'(bg_sum / longint'(bg_num));
			if (bg_num >= BG_HALVE_AT) begin
				bg_sum = bg_sum / 2;
				bg_num = bg_num / 2;
			end
		end
		seg_len = 0;
		r.intf_found = above;
		r.mode_snr = mode_v[15:0];
		r.intf_snr = above ? mode_v[15:0] : 16'sd0;
		r.background_snr = bg_avg[15:0];
		r.mode_bin = mi[5:0];
		segment_results.push_back(r);
	endfunction

	// Gate driver
	always @(posedge clk or negedge arst_n) begin : gate_drive
		int gap_now;
		if (!arst_n) begin
			gate_ch.valid <= 1'b0;
			gate_ch.data <= '0;
			src_gap <= 0;
		end else begin
			gap_now = src_gap;
			if (gate_ch.valid && gate_ch.ready) begin
				track_gate(gate_ch.data);
				if ($urandom_range(0, 63) == 0)
					src_burst = !src_burst;
				gap_now = src_burst ? 0 : $urandom_range(0, 15);
			end
			if (gate_ch.valid && !gate_ch.ready) begin
				// hold the transaction until taken
			end else if (gap_now > 0) begin
				gate_ch.valid <= 1'b0;
				gap_now--;
			end else if (gate_q.size() != 0) begin
				gate_ch.valid <= 1'b1;
				gate_ch.data <= gate_q.pop_front();
			end else begin
				gate_ch.valid <= 1'b0;
			end
			src_gap <= gap_now;
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin : result_watch
		int gap_now;
		result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_gap <= 0;
		end else begin
			gap_now = snk_gap;
			if (res_ch.valid && res_ch.ready) begin
				if (segment_results.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want = segment_results.pop_front();
					if (res_ch.data.intf_found !== want.intf_found)
						report("intf_found", res_ch.data.intf_found, want.intf_found);
					if (res_ch.data.mode_snr !== want.mode_snr)
						report("mode_snr", res_ch.data.mode_snr, want.mode_snr);
					if (res_ch.data.intf_snr !== want.intf_snr)
						report("intf_snr", res_ch.data.intf_snr, want.intf_snr);
					if (res_ch.data.background_snr !== want.background_snr)
						report("background_snr", res_ch.data.background_snr,
							want.background_snr);
					if (res_ch.data.mode_bin !== want.mode_bin)
						report("mode_bin", res_ch.data.mode_bin, want.mode_bin);
				end
				if ($urandom_range(0, 31) == 0)
					snk_burst = !snk_burst;
				gap_now = snk_burst ? 0 : $urandom_range(0, 15);
			end
			if (gap_now > 0) begin
				res_ch.ready <= 1'b0;
				gap_now--;
			end else begin
				res_ch.ready <= 1'b1;
			end
			snk_gap <= gap_now;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_HIST_MIN: hmin_m = int'(signed'(val));
			REG_BIN_WIDTH: bwidth_m = int'(val[12:0]);
			REG_BIN_COUNT: bcount_m = int'(val[6:0]);
			REG_TAIL_LEVEL: tail_m = longint'(val);
			REG_INTF_THRESHOLD: thresh_m = int'(signed'(val));
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] hmin, logic [15:0] bw, logic [15:0] bc,
			logic [15:0] tl, logic [15:0] thr);
		write_reg(REG_HIST_MIN, hmin);
		write_reg(REG_BIN_WIDTH, bw);
		write_reg(REG_BIN_COUNT, bc);
		write_reg(REG_TAIL_LEVEL, tl);
		write_reg(REG_INTF_THRESHOLD, thr);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Let the last segment pass finish before touching registers.
	task automatic drain;
		while (gate_q.size() != 0 || gate_ch.valid || segment_results.size() != 0)
			@(posedge clk);
		repeat (PASS_WAIT) @(posedge clk);
	endtask

	task automatic put_gate(int snr, bit miss, bit lst);
		gate_t g;
		g.snr = snr[15:0];
		g.missing = miss;
		g.last = lst;
		gate_q.push_back(g);
	endtask

	// Clustered segment around a point in the histogram, with some wild values.
	task automatic add_segment(int len);
		int bw, nb, centre, spread, v;
		bw = (bwidth_m == 0) ? 1 : bwidth_m;
		nb = (bcount_m == 0) ? 1 : ((bcount_m > BIN_DEPTH) ? BIN_DEPTH : bcount_m);
		centre = hmin_m + $urandom_range(0, bw * nb);
		spread = $urandom_range(0, bw * 3);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				v = $urandom;
			else
				v = centre + $urandom_range(0, 2 * spread) - spread;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			put_gate(v, $urandom_range(0, 9) == 0, i == len - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		cycles = 0;
		err_count = 0;
		seg_len = 0;
		bg_sum = 0;
		bg_num = 0;
		bg_avg = 0;
		src_burst = 1'b0;
		snk_burst = 1'b0;
		hmin_m = -160;
		bwidth_m = 16;
		bcount_m = 64;
		tail_m = 1311;
		thresh_m = 48;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// field extremes, all out of range: empty histogram
		put_gate(-32768, 1'b0, 1'b0);
		put_gate(32767, 1'b0, 1'b1);
		// all gates missing, including the closing one
		put_gate(0, 1'b1, 1'b0);
		put_gate(5, 1'b1, 1'b1);
		put_gate(100, 1'b1, 1'b1);
		// just below the lower edge still lands in bin 0
		put_gate(-161, 1'b0, 1'b0);
		put_gate(-175, 1'b0, 1'b0);
		put_gate(-160, 1'b0, 1'b0);
		put_gate(-150, 1'b0, 1'b1);
		// mean equal to the threshold: neither interference nor background
		put_gate(48, 1'b0, 1'b1);
		put_gate(200, 1'b0, 1'b0);
		put_gate(210, 1'b0, 1'b1);
		put_gate(-100, 1'b0, 1'b0);
		put_gate(-90, 1'b0, 1'b1);
		// negative mean truncates toward zero
		put_gate(-101, 1'b0, 1'b0);
		put_gate(-100, 1'b0, 1'b1);
		put_gate(-1, 1'b0, 1'b0);
		put_gate(1000, 1'b0, 1'b0);
		put_gate(900, 1'b0, 1'b1);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure(-16'sd160, 16'd16, 16'd64, 16'd1311, 16'sd48);
				1: configure(16'h8000, 16'd4096, 16'd0, 16'd0, 16'h8000);
				2: configure(16'h7fff, 16'd0, 16'd127, 16'hffff, 16'h7fff);
				3: configure(16'hff00, 16'h1fff, 16'd1, 16'd30000, 16'h0000);
				4: configure(-16'sd400, 16'd3, 16'd20, 16'd8000, -16'sd100);
				default: configure(16'($urandom), 16'($urandom_range(1, 4096)),
					16'($urandom_range(1, 64)), 16'($urandom), 16'($urandom));
			endcase
			for (int s = 0; s < 6; s++)
				add_segment($urandom_range(1, 10));
			drain();
		end

		// many short segments below threshold push the background past halving
		configure(-16'sd160, 16'd16, 16'd4, 16'd1311, 16'h7fff);
		for (int s = 0; s < 520; s++)
			put_gate($urandom_range(0, 64) - 160, 1'b0, 1'b1);
		drain();

		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
